/* rtl/core/sdc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the segmented DAC calibration block.
// Used by every module under rtl/core; depends on nothing.
package sdc_pkg;

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    localparam logic [1:0] CFG_GAIN_VOLTAGE   = 2'd0;
    localparam logic [1:0] CFG_OFFSET_VOLTAGE = 2'd1;
    localparam logic [1:0] CFG_GAIN_CURRENT   = 2'd2;
    localparam logic [1:0] CFG_OFFSET_CURRENT = 2'd3;

    // A gain of 1e-5 in Q8.24 is 167.77, so anything below 168 is too small.
    localparam logic signed [31:0] GAIN_THRESHOLD = 32'sd168;
    localparam logic [15:0]        CODE_MAX       = 16'hFFFF;

    typedef struct packed
    {
        op_t                operation;
        logic               quantity;
        logic               direction;
        logic [15:0]        setpoint;
        logic [3:0]         entry_segment;
        logic signed [31:0] entry_gain;
        logic signed [31:0] entry_offset;
    } in_item_t;

    typedef struct packed
    {
        logic [15:0] dac_code;
        logic [3:0]  segment_used;
        logic        used_default;
        logic        code_saturated;
    } out_item_t;

    typedef struct packed
    {
        logic signed [31:0] gain;
        logic signed [31:0] offset;
    } coef_t;

    typedef struct packed
    {
        logic signed [31:0] gain_voltage;
        logic signed [31:0] offset_voltage;
        logic signed [31:0] gain_current;
        logic signed [31:0] offset_current;
    } cfg_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

    typedef struct packed
    {
        op_t         operation;
        logic        quantity;
        logic [15:0] setpoint;
        logic [3:0]  segment;
    } stage_info_t;

endpackage

/* rtl/core/sdc_coef_mem.sv */
`timescale 1ns / 1ps
// Coefficient table: one synchronous memory of gain/offset pairs with a
// registered read and a clearing pass after reset. Depends on sdc_pkg.
module sdc_coef_mem #(
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sdc_pkg::mem_req_t req,
    input  logic [ADDR_W-1:0] addr,
    input  sdc_pkg::coef_t    wdata,
    output sdc_pkg::coef_t    rdata,
    output logic              clearing
);

    localparam int DEPTH = 2 ** ADDR_W;

    sdc_pkg::coef_t    mem [DEPTH];
    sdc_pkg::coef_t    rdata_reg;
    logic              clear_busy_reg;
    logic              clear_busy_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == {ADDR_W{1'b1}})
            begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clear_busy_reg;

endmodule

/* rtl/core/sdc_index.sv */
`timescale 1ns / 1ps
// Front stage: takes requests, finds the segment by reciprocal multiply
// with one correction step, and drives the table port. Depends on sdc_pkg.
module sdc_index #(
    parameter int SEGMENT_COUNT        = 16,
    parameter int VOLTAGE_SEGMENT_STEP = 1000,
    parameter int CURRENT_SEGMENT_STEP = 1000
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  sdc_pkg::in_item_t      in_item,
    input  logic                   clearing,
    input  logic                   s2_ready,
    output logic                   in_stall,
    output sdc_pkg::mem_req_t      mem_req,
    output logic [$clog2(SEGMENT_COUNT)+1:0] mem_addr,
    output sdc_pkg::coef_t         mem_wdata,
    output logic                   s1_valid,
    output sdc_pkg::stage_info_t   s1_info
);

    localparam int SEG_W = $clog2(SEGMENT_COUNT);
    localparam logic [15:0] STEP_V = 16'(VOLTAGE_SEGMENT_STEP);
    localparam logic [15:0] STEP_C = 16'(CURRENT_SEGMENT_STEP);
    localparam logic [16:0] RECIP_V = 17'(65536 / VOLTAGE_SEGMENT_STEP);
    localparam logic [16:0] RECIP_C = 17'(65536 / CURRENT_SEGMENT_STEP);
    localparam logic [16:0] SEG_LAST = 17'(SEGMENT_COUNT - 1);
    localparam logic [8:0]  SEG_LIMIT = 9'(SEGMENT_COUNT);

    logic              s1_valid_reg;
    sdc_pkg::in_item_t s1_item_reg;
    logic [15:0]       s1_q0_reg;
    logic              s1_ready;
    logic              accept;
    logic [16:0]       recip;
    logic [32:0]       recip_prod;
    logic [15:0]       step;
    logic [31:0]       q0_step;
    logic [31:0]       remainder;
    logic [16:0]       quot;
    logic [SEG_W-1:0]  seg;
    logic              load_in_range;
    logic              advance;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = clearing || !s1_ready;
    assign accept   = in_valid && !in_stall;

    assign recip      = in_item.quantity ? RECIP_C : RECIP_V;
    assign recip_prod = {17'd0, in_item.setpoint} * {16'd0, recip};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_item_reg <= in_item;
            s1_q0_reg   <= recip_prod[31:16];
        end
    end

    always_comb
    begin
        step      = s1_item_reg.quantity ? STEP_C : STEP_V;
        q0_step   = {16'd0, s1_q0_reg} * {16'd0, step};
        remainder = {16'd0, s1_item_reg.setpoint} - q0_step;
        quot      = {1'b0, s1_q0_reg};
        if (remainder >= {16'd0, step})
        begin
            quot = {1'b0, s1_q0_reg} + 17'd1;
        end
        if (quot > SEG_LAST)
        begin
            seg = SEG_W'(SEG_LAST);
        end
        else
        begin
            seg = SEG_W'(quot);
        end
    end

    assign load_in_range = {5'd0, s1_item_reg.entry_segment} < SEG_LIMIT;
    assign advance       = s1_valid_reg && s2_ready;

    always_comb
    begin
        mem_req.rd_en = s2_ready;
        mem_req.wr_en = advance && (s1_item_reg.operation == sdc_pkg::OP_LOAD)
                        && load_in_range;
        if (s1_item_reg.operation == sdc_pkg::OP_LOAD)
        begin
            mem_addr = {s1_item_reg.quantity, s1_item_reg.direction,
                        SEG_W'(s1_item_reg.entry_segment)};
        end
        else
        begin
            mem_addr = {s1_item_reg.quantity, s1_item_reg.direction, seg};
        end
    end

    assign mem_wdata.gain   = s1_item_reg.entry_gain;
    assign mem_wdata.offset = s1_item_reg.entry_offset;

    assign s1_valid           = s1_valid_reg;
    assign s1_info.operation  = s1_item_reg.operation;
    assign s1_info.quantity   = s1_item_reg.quantity;
    assign s1_info.setpoint   = s1_item_reg.setpoint;
    assign s1_info.segment    = 4'(seg);

endmodule

/* rtl/core/sdc_convert.sv */
`timescale 1ns / 1ps
// Back stages: default fallback and multiply, offset add with clamp, and
// the output register. Depends on sdc_pkg.
module sdc_convert (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s1_valid,
    input  sdc_pkg::stage_info_t s1_info,
    input  sdc_pkg::coef_t       rdata,
    input  sdc_pkg::cfg_t        cfg,
    output logic                 s2_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sdc_pkg::out_item_t   out_item
);

    logic                 s2_valid_reg;
    sdc_pkg::stage_info_t s2_info_reg;
    logic                 s3_valid_reg;
    logic                 s3_is_load_reg;
    logic                 s3_zero_reg;
    logic [3:0]           s3_seg_reg;
    logic                 s3_default_reg;
    logic signed [48:0]   s3_prod_reg;
    logic signed [31:0]   s3_offset_reg;
    logic                 s4_valid_reg;
    sdc_pkg::out_item_t   s4_item_reg;
    sdc_pkg::out_item_t   s4_item_next;

    logic                 s3_ready;
    logic                 s4_ready;
    logic                 use_default;
    logic signed [31:0]   gain_sel;
    logic signed [31:0]   offset_sel;
    logic signed [48:0]   prod_next;
    logic signed [49:0]   sum;
    logic [25:0]          code_wide;

    assign s4_ready = !s4_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;

    always_comb
    begin
        use_default = rdata.gain < sdc_pkg::GAIN_THRESHOLD;
        gain_sel    = rdata.gain;
        offset_sel  = rdata.offset;
        if (use_default)
        begin
            gain_sel   = s2_info_reg.quantity ? cfg.gain_current : cfg.gain_voltage;
            offset_sel = s2_info_reg.quantity ? cfg.offset_current : cfg.offset_voltage;
        end
        prod_next = $signed({1'b0, s2_info_reg.setpoint}) * gain_sel;
    end

    always_comb
    begin
        sum       = 50'(s3_prod_reg) + (50'(s3_offset_reg) <<< 16);
        code_wide = sum[49:24];
        s4_item_next = '0;
        if (!s3_is_load_reg)
        begin
            s4_item_next.segment_used = s3_seg_reg;
            s4_item_next.used_default = s3_default_reg;
            if (!s3_zero_reg && !sum[49] && (sum != '0))
            begin
                if (code_wide > {10'd0, sdc_pkg::CODE_MAX})
                begin
                    s4_item_next.dac_code       = sdc_pkg::CODE_MAX;
                    s4_item_next.code_saturated = 1'b1;
                end
                else
                begin
                    s4_item_next.dac_code = code_wide[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_info_reg <= s1_info;
        end
        if (s3_ready)
        begin
            s3_is_load_reg <= s2_info_reg.operation == sdc_pkg::OP_LOAD;
            s3_zero_reg    <= s2_info_reg.setpoint == 16'd0;
            s3_seg_reg     <= s2_info_reg.segment;
            s3_default_reg <= use_default;
            s3_prod_reg    <= prod_next;
            s3_offset_reg  <= offset_sel;
        end
        if (s4_ready)
        begin
            s4_item_reg <= s4_item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

/* rtl/core/segmented_dac_calibration.sv */
`timescale 1ns / 1ps
// Top level of the segmented DAC calibration block: configuration registers
// and the pipeline built from sdc_index, sdc_coef_mem and sdc_convert.
//
//   Channel   Direction  Handshake              Payload
//   in        request    in_valid / in_stall    in_item  (sdc_pkg::in_item_t)
//   out       result     out_valid / out_stall  out_item (sdc_pkg::out_item_t)
//   cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; each result passes
// through a four-stage pipeline around one table read and three multipliers.
// After reset the table is cleared, one entry per cycle, through all of its
// 4 * 2**clog2(SEGMENT_COUNT) entries (64 by default), while in_stall is high.
// A stalled output lets requests keep entering until every stage holds one.
// Configuration writes are always taken.
module segmented_dac_calibration #(
    parameter int SEGMENT_COUNT        = 16,
    parameter int VOLTAGE_SEGMENT_STEP = 1000,
    parameter int CURRENT_SEGMENT_STEP = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sdc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sdc_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int ADDR_W = $clog2(SEGMENT_COUNT) + 2;

    sdc_pkg::cfg_t        cfg_reg;
    sdc_pkg::cfg_t        cfg_next;
    sdc_pkg::mem_req_t    mem_req;
    logic [ADDR_W-1:0]    mem_addr;
    sdc_pkg::coef_t       mem_wdata;
    sdc_pkg::coef_t       mem_rdata;
    logic                 clearing;
    logic                 s2_ready;
    logic                 s1_valid;
    sdc_pkg::stage_info_t s1_info;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sdc_pkg::CFG_GAIN_VOLTAGE:   cfg_next.gain_voltage   = cfg_data;
                sdc_pkg::CFG_OFFSET_VOLTAGE: cfg_next.offset_voltage = cfg_data;
                sdc_pkg::CFG_GAIN_CURRENT:   cfg_next.gain_current   = cfg_data;
                sdc_pkg::CFG_OFFSET_CURRENT: cfg_next.offset_current = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdc_index #(
        .SEGMENT_COUNT        (SEGMENT_COUNT),
        .VOLTAGE_SEGMENT_STEP (VOLTAGE_SEGMENT_STEP),
        .CURRENT_SEGMENT_STEP (CURRENT_SEGMENT_STEP)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .clearing  (clearing),
        .s2_ready  (s2_ready),
        .in_stall  (in_stall),
        .mem_req   (mem_req),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .s1_valid  (s1_valid),
        .s1_info   (s1_info)
    );

    sdc_coef_mem #(
        .ADDR_W (ADDR_W)
    ) u_coef_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    sdc_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_info   (s1_info),
        .rdata     (mem_rdata),
        .cfg       (cfg_reg),
        .s2_ready  (s2_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

/* tb/sv/segmented_dac_calibration_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for segmented_dac_calibration: directed and random
// load/convert requests checked against an in-bench calibration predictor.
// Depends on sdc_pkg and the segmented_dac_calibration RTL only.
module segmented_dac_calibration_tb;

    localparam int SEG_COUNT      = 16;
    localparam int VOLTAGE_STEP   = 1000;
    localparam int CURRENT_STEP   = 1000;
    localparam int PHASE_REQUESTS = 150;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    sdc_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    sdc_pkg::out_item_t out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data  = '0;

    sdc_pkg::in_item_t  queued_requests[$];
    sdc_pkg::out_item_t predicted_codes[$];

    logic signed [31:0] seg_gain   [2][2][SEG_COUNT];
    logic signed [31:0] seg_offset [2][2][SEG_COUNT];
    sdc_pkg::cfg_t      fallback_coefs;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit pressure_phase    = 1'b0;
    bit pressure_done     = 1'b0;
    int hold_left         = 0;
    int idle_cycles       = 0;
    int failures          = 0;

    segmented_dac_calibration #(
        .SEGMENT_COUNT        (SEG_COUNT),
        .VOLTAGE_SEGMENT_STEP (VOLTAGE_STEP),
        .CURRENT_SEGMENT_STEP (CURRENT_STEP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Loads update the segment table; converts pick a segment, fall back to the
    // defaults on a tiny gain and evaluate setpoint * gain + offset * 2**16 in Q.24.
    function automatic sdc_pkg::out_item_t calibrate_request(sdc_pkg::in_item_t req);
        sdc_pkg::out_item_t res;
        int unsigned        seg;
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        longint             sum;
        res = '0;
        if (req.operation == sdc_pkg::OP_LOAD)
        begin
            if (req.entry_segment < SEG_COUNT)
            begin
                seg_gain[req.quantity][req.direction][req.entry_segment]   = req.entry_gain;
                seg_offset[req.quantity][req.direction][req.entry_segment] = req.entry_offset;
            end
            return res;
        end
        seg = req.setpoint / (req.quantity ? CURRENT_STEP : VOLTAGE_STEP);
        if (seg > SEG_COUNT - 1)
            seg = SEG_COUNT - 1;
        gain   = seg_gain[req.quantity][req.direction][seg];
        offset = seg_offset[req.quantity][req.direction][seg];
        if (gain < sdc_pkg::GAIN_THRESHOLD)
        begin
            res.used_default = 1'b1;
            gain   = req.quantity ? fallback_coefs.gain_current : fallback_coefs.gain_voltage;
            offset = req.quantity ? fallback_coefs.offset_current
                                  : fallback_coefs.offset_voltage;
        end
        if (req.setpoint != 0)
        begin
            sum = longint'(req.setpoint) * longint'(gain) + longint'(offset) * 64'sd65536;
            if (sum > 0)
            begin
                if ((sum >>> 24) > longint'(sdc_pkg::CODE_MAX))
                begin
                    res.dac_code       = sdc_pkg::CODE_MAX;
                    res.code_saturated = 1'b1;
                end
                else
                    res.dac_code = 16'(sum >>> 24);
            end
        end
        res.segment_used = 4'(seg);
        return res;
    endfunction

    function automatic logic signed [31:0] random_gain();
        case ($urandom_range(5))
            0: return sdc_pkg::GAIN_THRESHOLD - 4 + $urandom_range(8);
            1: return $urandom_range(32'h0200_0000, 32'h0010_0000);
            2: return $urandom;
            3: return -$signed($urandom_range(32'h0200_0000));
            4: return 32'sd0;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] random_offset();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            2: return 32'sd0;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [15:0] random_setpoint();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'($urandom_range(SEG_COUNT * VOLTAGE_STEP - 1));
            2: return 16'($urandom);
            3: return 16'(VOLTAGE_STEP * $urandom_range(16, 1) + $urandom_range(2) - 1);
            default: return 16'($urandom_range(3000));
        endcase
    endfunction

    function automatic sdc_pkg::in_item_t random_request();
        sdc_pkg::in_item_t req;
        req.operation     = ($urandom_range(99) < 30) ? sdc_pkg::OP_LOAD : sdc_pkg::OP_CONVERT;
        req.quantity      = 1'($urandom_range(1));
        req.direction     = 1'($urandom_range(1));
        req.setpoint      = random_setpoint();
        req.entry_segment = 4'($urandom_range(SEG_COUNT - 1));
        req.entry_gain    = random_gain();
        req.entry_offset  = random_offset();
        return req;
    endfunction

    function automatic sdc_pkg::cfg_t random_fallback();
        sdc_pkg::cfg_t coefs;
        coefs.gain_voltage   = random_gain();
        coefs.offset_voltage = random_offset();
        coefs.gain_current   = random_gain();
        coefs.offset_current = random_offset();
        return coefs;
    endfunction

    task automatic queue_load(logic q, logic d, logic [3:0] seg, logic [31:0] gain,
                              logic [31:0] offset);
        sdc_pkg::in_item_t req;
        req               = random_request();
        req.operation     = sdc_pkg::OP_LOAD;
        req.quantity      = q;
        req.direction     = d;
        req.entry_segment = seg;
        req.entry_gain    = gain;
        req.entry_offset  = offset;
        queued_requests.push_back(req);
    endtask

    task automatic queue_convert(logic q, logic d, logic [15:0] setpoint);
        sdc_pkg::in_item_t req;
        req           = random_request();
        req.operation = sdc_pkg::OP_CONVERT;
        req.quantity  = q;
        req.direction = d;
        req.setpoint  = setpoint;
        queued_requests.push_back(req);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queued_requests.push_back(random_request());
    endtask

    task automatic write_fallback(sdc_pkg::cfg_t coefs);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx = '{sdc_pkg::CFG_GAIN_VOLTAGE, sdc_pkg::CFG_OFFSET_VOLTAGE,
                sdc_pkg::CFG_GAIN_CURRENT, sdc_pkg::CFG_OFFSET_CURRENT};
        val = '{coefs.gain_voltage, coefs.offset_voltage, coefs.gain_current,
                coefs.offset_current};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        fallback_coefs = coefs;
    endtask

    task automatic wait_drained();
        while (queued_requests.size() != 0 || in_valid || predicted_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            predicted_codes.push_back(calibrate_request(in_item));
        if (!in_valid || !in_stall)
        begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                in_item  <= queued_requests.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sdc_pkg::out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (predicted_codes.size() == 0)
            begin
                $display("%0t ns: result with no request pending, got %p", $time, out_item);
                failures++;
            end
            else
            begin
                want = predicted_codes.pop_front();
                check_field("dac_code", want.dac_code, out_item.dac_code);
                check_field("segment_used", want.segment_used, out_item.segment_used);
                check_field("used_default", want.used_default, out_item.used_default);
                check_field("code_saturated", want.code_saturated, out_item.code_saturated);
            end
        end
        // The long hold lets the pipeline fill so that in_stall must rise.
        if (pressure_phase && !pressure_done)
        begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        sdc_pkg::cfg_t first_coefs;
        sdc_pkg::cfg_t extreme_coefs;
        for (int q = 0; q < 2; q++)
            for (int d = 0; d < 2; d++)
                for (int s = 0; s < SEG_COUNT; s++)
                begin
                    seg_gain[q][d][s]   = '0;
                    seg_offset[q][d][s] = '0;
                end
        fallback_coefs = '0;
        first_coefs.gain_voltage   = 32'sh0100_0000;
        first_coefs.offset_voltage = 32'sd256;
        first_coefs.gain_current   = 32'sd80;
        first_coefs.offset_current = 32'sd25728;
        extreme_coefs.gain_voltage   = 32'h7FFF_FFFF;
        extreme_coefs.offset_voltage = 32'h8000_0000;
        extreme_coefs.gain_current   = 32'h8000_0000;
        extreme_coefs.offset_current = 32'h7FFF_FFFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 22;
        receiver_idle_pct = 82;
        write_fallback(first_coefs);
        queue_convert(1'b0, 1'b0, 16'd0);
        queue_convert(1'b0, 1'b0, 16'hFFFF);
        queue_convert(1'b1, 1'b1, 16'd1);
        queue_load(1'b0, 1'b0, 4'd0, 32'sd168, 32'sd0);
        queue_load(1'b0, 1'b0, 4'd1, 32'sd167, 32'sd100);
        queue_load(1'b0, 1'b1, 4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_load(1'b1, 1'b0, 4'd15, 32'h8000_0000, 32'h8000_0000);
        queue_load(1'b1, 1'b1, 4'd5, 32'sh0200_0000, -32'sd256000);
        queue_load(1'b0, 1'b0, 4'd2, 32'sh0100_0000, -32'sh7FFF_FFFF);
        queue_convert(1'b0, 1'b0, 16'd999);
        queue_convert(1'b0, 1'b0, 16'd1000);
        queue_convert(1'b0, 1'b1, 16'd16000);
        queue_convert(1'b0, 1'b1, 16'd15999);
        queue_convert(1'b0, 1'b1, 16'd0);
        queue_convert(1'b1, 1'b0, 16'hFFFF);
        queue_convert(1'b1, 1'b1, 16'd5500);
        queue_convert(1'b1, 1'b1, 16'd5000);
        queue_convert(1'b0, 1'b0, 16'd2500);
        queue_convert(1'b1, 1'b0, 16'd14999);
        queue_random(PHASE_REQUESTS);
        wait_drained();

        sender_idle_pct   = 82;
        receiver_idle_pct = 22;
        write_fallback(extreme_coefs);
        queue_random(PHASE_REQUESTS);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_fallback(random_fallback());
        queue_random(PHASE_REQUESTS);
        pressure_phase = 1'b1;
        wait_drained();

        failures += predicted_codes.size();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
